/* hdl/middle_insert_queue_macros.svh */
// assertion macros used by the checker file
`ifndef MIDDLE_INSERT_QUEUE_MACROS_SVH
`define MIDDLE_INSERT_QUEUE_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define MIQ_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("middle_insert_queue assertion failed");

// concurrent assertion on the block clock and reset
`define MIQ_ASSERT(label, prop) \
    `MIQ_ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

/* hdl/miq_pkg.sv */
// types and constants of the middle insert queue
package miq_pkg;

    localparam int FUNC_W = 2;
    localparam int VAL_OUT_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W = 11;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_STORED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POPPED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic signed [VAL_OUT_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic signed [VAL_OUT_W-1:0] popped_value;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;

    typedef struct packed {
        logic push_ok;
        logic ins_ok;
        logic pop_ok;
        logic pop_empty;
        logic drop;
    } t_op_flags;

endpackage

/* hdl/miq_ram.sv */
// generic single-write, single-read ram with registered read data
module miq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/miq_ring_ctrl.sv */
// head and count state of both ring halves, operation decode and rebalancing
module miq_ring_ctrl #(
    parameter int HALF_DEPTH = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [miq_pkg::FUNC_W-1:0]    i_func,
    input  logic [VALUE_WIDTH-1:0]        i_value,
    input  logic [VALUE_WIDTH-1:0]        i_front_head_val,
    input  logic [VALUE_WIDTH-1:0]        i_back_head_val,
    output logic [$clog2(HALF_DEPTH)-1:0] o_front_rd_addr,
    output logic [$clog2(HALF_DEPTH)-1:0] o_back_rd_addr,
    output logic                          o_front_we,
    output logic [$clog2(HALF_DEPTH)-1:0] o_front_wr_addr,
    output logic [VALUE_WIDTH-1:0]        o_front_wr_data,
    output logic                          o_back_we,
    output logic [$clog2(HALF_DEPTH)-1:0] o_back_wr_addr,
    output logic [VALUE_WIDTH-1:0]        o_back_wr_data,
    output miq_pkg::t_op_flags            o_flags,
    output logic [miq_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int AW = $clog2(HALF_DEPTH);
    localparam int CW = $clog2(HALF_DEPTH + 1);
    localparam int TW = CW + 1;
    localparam logic [AW-1:0] HEAD_LAST = AW'(HALF_DEPTH - 1);
    localparam logic [AW:0] HD_SUM = (AW + 1)'(HALF_DEPTH);
    localparam logic [CW-1:0] HD_CNT = CW'(HALF_DEPTH);
    localparam logic [TW-1:0] FULL_CNT = TW'(2 * HALF_DEPTH);

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] h);
        logic [AW-1:0] r;
        r = (h == HEAD_LAST) ? '0 : h + AW'(1);
        return r;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] h);
        logic [AW-1:0] r;
        r = (h == '0) ? HEAD_LAST : h - AW'(1);
        return r;
    endfunction

    // count is below the ring size wherever this is used
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
        logic [AW:0] s;
        s = (AW + 1)'(h) + (AW + 1)'(c[AW-1:0]);
        if (s >= HD_SUM) begin
            s = s - HD_SUM;
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] r_front_head, n_front_head;
    logic [CW-1:0] r_front_count, n_front_count;
    logic [AW-1:0] r_back_head, n_back_head;
    logic [CW-1:0] r_back_count, n_back_count;

    logic [TW-1:0] total;
    logic          full;
    logic          is_store;
    logic          drop;
    logic          push_ok;
    logic          ins_ok;
    logic          pop_empty;
    logic          pop_ok;
    logic [AW-1:0] back_head1;
    logic [CW-1:0] back_count1;
    logic [AW-1:0] front_head1;
    logic [CW-1:0] front_count1;
    logic          move;
    logic [VALUE_WIDTH-1:0] moved;

    always_comb begin
        total = TW'(r_front_count) + TW'(r_back_count);
        full = (total >= FULL_CNT) || (r_back_count >= HD_CNT);
        is_store = (i_func == miq_pkg::FUNC_PUSH) || (i_func == miq_pkg::FUNC_INSERT);
        drop = i_valid && is_store && full;
        push_ok = i_valid && (i_func == miq_pkg::FUNC_PUSH) && !full;
        ins_ok = i_valid && (i_func == miq_pkg::FUNC_INSERT) && !full;
        pop_empty = i_valid && (i_func == miq_pkg::FUNC_POP) && (r_front_count == '0);
        pop_ok = i_valid && (i_func == miq_pkg::FUNC_POP) && (r_front_count != '0);

        back_head1 = ins_ok ? ring_dec(r_back_head) : r_back_head;
        back_count1 = (push_ok || ins_ok) ? r_back_count + CW'(1) : r_back_count;
        front_head1 = pop_ok ? ring_inc(r_front_head) : r_front_head;
        front_count1 = pop_ok ? r_front_count - CW'(1) : r_front_count;

        move = i_valid && (back_count1 > front_count1) && (front_count1 < HD_CNT);
        // the head of the back half is the new value when it was just written there
        if (ins_ok || (push_ok && (r_back_count == '0))) begin
            moved = i_value;
        end else begin
            moved = i_back_head_val;
        end

        n_front_head = front_head1;
        n_front_count = move ? front_count1 + CW'(1) : front_count1;
        n_back_head = move ? ring_inc(back_head1) : back_head1;
        n_back_count = move ? back_count1 - CW'(1) : back_count1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_head <= '0;
            r_front_count <= '0;
            r_back_head <= '0;
            r_back_count <= '0;
        end else begin
            r_front_head <= n_front_head;
            r_front_count <= n_front_count;
            r_back_head <= n_back_head;
            r_back_count <= n_back_count;
        end
    end

    assign o_front_rd_addr = n_front_head;
    assign o_back_rd_addr = n_back_head;
    assign o_front_we = move;
    assign o_front_wr_addr = ring_add(front_head1, front_count1);
    assign o_front_wr_data = moved;
    assign o_back_we = push_ok || ins_ok;
    assign o_back_wr_addr = ins_ok ? back_head1 : ring_add(r_back_head, r_back_count);
    assign o_back_wr_data = i_value;
    assign o_flags = '{push_ok: push_ok, ins_ok: ins_ok, pop_ok: pop_ok,
                       pop_empty: pop_empty, drop: drop};
    assign o_occupancy = miq_pkg::OCC_W'(TW'(n_front_count) + TW'(n_back_count));

endmodule

/* hdl/middle_insert_queue.sv */
// top level of the queue with insertion behind its middle
//
// channel   handshake        payload  direction
// request   start / busy     i_req    in
// result    o_done strobe    o_rsp    out
//
// one transaction is accepted in every cycle; busy stays low
// the result passes the input register and then the result register;
// both half heads are read ahead from ram
// synchronous active-low reset empties both halves, ram contents are kept
// the receiver cannot stall: o_done is high for exactly one cycle per result
module middle_insert_queue #(
    parameter int HALF_DEPTH = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  miq_pkg::t_req    i_req,
    output logic             o_done,
    output miq_pkg::t_rsp    o_rsp
);

    localparam int AW = $clog2(HALF_DEPTH);

    logic                   accept;
    logic                   r_valid;
    logic [miq_pkg::FUNC_W-1:0] r_func;
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_front_byp;
    logic [VALUE_WIDTH-1:0] r_front_byp_data;
    logic                   r_back_byp;
    logic [VALUE_WIDTH-1:0] r_back_byp_data;
    logic                   r_done;
    miq_pkg::t_rsp          r_rsp;
    miq_pkg::t_rsp          n_rsp;

    logic [AW-1:0]          front_rd_addr;
    logic [AW-1:0]          back_rd_addr;
    logic                   front_we;
    logic [AW-1:0]          front_wr_addr;
    logic [VALUE_WIDTH-1:0] front_wr_data;
    logic                   back_we;
    logic [AW-1:0]          back_wr_addr;
    logic [VALUE_WIDTH-1:0] back_wr_data;
    logic [VALUE_WIDTH-1:0] front_rd_data;
    logic [VALUE_WIDTH-1:0] back_rd_data;
    logic [VALUE_WIDTH-1:0] front_head_val;
    logic [VALUE_WIDTH-1:0] back_head_val;
    miq_pkg::t_op_flags     flags;
    logic [miq_pkg::OCC_W-1:0] occupancy;

    assign busy = 1'b0;
    assign accept = start && !busy;

    miq_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(HALF_DEPTH)
    ) u_front_ram (
        .i_clk(i_clk),
        .i_we(front_we),
        .i_wr_addr(front_wr_addr),
        .i_wr_data(front_wr_data),
        .i_rd_addr(front_rd_addr),
        .o_rd_data(front_rd_data)
    );

    miq_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(HALF_DEPTH)
    ) u_back_ram (
        .i_clk(i_clk),
        .i_we(back_we),
        .i_wr_addr(back_wr_addr),
        .i_wr_data(back_wr_data),
        .i_rd_addr(back_rd_addr),
        .o_rd_data(back_rd_data)
    );

    // a head written in the same cycle it is read comes from the bypass
    assign front_head_val = r_front_byp ? r_front_byp_data : front_rd_data;
    assign back_head_val = r_back_byp ? r_back_byp_data : back_rd_data;

    miq_ring_ctrl #(
        .HALF_DEPTH(HALF_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ring_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_valid),
        .i_func(r_func),
        .i_value(r_value),
        .i_front_head_val(front_head_val),
        .i_back_head_val(back_head_val),
        .o_front_rd_addr(front_rd_addr),
        .o_back_rd_addr(back_rd_addr),
        .o_front_we(front_we),
        .o_front_wr_addr(front_wr_addr),
        .o_front_wr_data(front_wr_data),
        .o_back_we(back_we),
        .o_back_wr_addr(back_wr_addr),
        .o_back_wr_data(back_wr_data),
        .o_flags(flags),
        .o_occupancy(occupancy)
    );

    always_comb begin
        n_rsp.occupancy = occupancy;
        n_rsp.popped_value = '0;
        if (flags.pop_ok) begin
            n_rsp.status = miq_pkg::STAT_POPPED;
            n_rsp.popped_value = miq_pkg::VAL_OUT_W'($signed(front_head_val));
        end else if (flags.pop_empty) begin
            n_rsp.status = miq_pkg::STAT_EMPTY;
            n_rsp.popped_value = '1;
        end else if (flags.drop) begin
            n_rsp.status = miq_pkg::STAT_FULL;
        end else begin
            n_rsp.status = miq_pkg::STAT_STORED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_valid <= accept;
            r_done <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= i_req.func;
        r_value <= VALUE_WIDTH'($unsigned(i_req.value));
        r_front_byp <= front_we && (front_wr_addr == front_rd_addr);
        r_front_byp_data <= front_wr_data;
        r_back_byp <= back_we && (back_wr_addr == back_rd_addr);
        r_back_byp_data <= back_wr_data;
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp = r_rsp;

endmodule

/* hdl/miq_checker.sv */
// port-level checks of the middle insert queue and their bind
`include "middle_insert_queue_macros.svh"

module miq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input miq_pkg::t_rsp o_rsp
);

    logic empty_rsp;
    logic quiet_rsp;

    assign empty_rsp = o_done && (o_rsp.status == miq_pkg::STAT_EMPTY);
    assign quiet_rsp = o_done && ((o_rsp.status == miq_pkg::STAT_FULL) ||
                                  (o_rsp.status == miq_pkg::STAT_STORED));

    `MIQ_ASSERT(a_done_follows_accept, start && !busy |-> ##2 o_done)
    `MIQ_ASSERT(a_done_has_cause, o_done |-> $past(start && !busy, 2))
    `MIQ_ASSERT(a_empty_pop, empty_rsp |-> (o_rsp.popped_value == '1) && (o_rsp.occupancy == '0))
    `MIQ_ASSERT(a_no_pop_zero, quiet_rsp |-> o_rsp.popped_value == '0)

endmodule

bind middle_insert_queue miq_checker u_miq_checker (.*);

/* tb/middle_insert_queue_test.sv */
// testbench for the middle insert queue: directed and random operations against a predictor
`timescale 1ns / 100ps

module middle_insert_queue_test;

    localparam int HALF = 512;
    localparam int VAL_W = 32;
    localparam int EXP_DEPTH = 64;
    localparam logic [miq_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    miq_pkg::t_req i_req = '0;
    logic o_done;
    miq_pkg::t_rsp o_rsp;

    middle_insert_queue #(
        .HALF_DEPTH(HALF),
        .VALUE_WIDTH(VAL_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_done(o_done),
        .o_rsp(o_rsp)
    );

    // predictor state: lead half holds the head, tail half the rest
    logic signed [VAL_W-1:0] lead_ring [HALF];
    logic signed [VAL_W-1:0] tail_ring [HALF];
    int lead_head = 0;
    int lead_count = 0;
    int tail_head = 0;
    int tail_count = 0;

    // expected results in flight, kept in a small ring
    miq_pkg::t_rsp expected_rsp [EXP_DEPTH];
    int exp_wr_idx = 0;
    int exp_rd_idx = 0;
    bit failed = 1'b0;
    int burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int queue_level();
        return lead_count + tail_count;
    endfunction

    function automatic miq_pkg::t_rsp apply_queue_op(miq_pkg::t_req req);
        miq_pkg::t_rsp rsp;
        logic signed [VAL_W-1:0] moved;
        rsp.status = miq_pkg::STAT_STORED;
        rsp.popped_value = '0;
        if (req.func == miq_pkg::FUNC_PUSH || req.func == miq_pkg::FUNC_INSERT) begin
            if (queue_level() >= 2 * HALF || tail_count >= HALF) begin
                rsp.status = miq_pkg::STAT_FULL;
            end else if (req.func == miq_pkg::FUNC_PUSH) begin
                tail_ring[(tail_head + tail_count) % HALF] = req.value;
                tail_count++;
            end else begin
                tail_head = (tail_head == 0) ? HALF - 1 : tail_head - 1;
                tail_ring[tail_head] = req.value;
                tail_count++;
            end
        end else if (req.func == miq_pkg::FUNC_POP) begin
            if (lead_count == 0) begin
                rsp.status = miq_pkg::STAT_EMPTY;
                rsp.popped_value = -1;
            end else begin
                rsp.popped_value = lead_ring[lead_head];
                lead_head = (lead_head + 1) % HALF;
                lead_count--;
                rsp.status = miq_pkg::STAT_POPPED;
            end
        end
        // rebalance one element from the tail half into the lead half
        if (tail_count > lead_count && lead_count < HALF) begin
            moved = tail_ring[tail_head];
            tail_head = (tail_head + 1) % HALF;
            tail_count--;
            lead_ring[(lead_head + lead_count) % HALF] = moved;
            lead_count++;
        end
        rsp.occupancy = miq_pkg::OCC_W'(queue_level());
        return rsp;
    endfunction

    task automatic send_op(input logic [miq_pkg::FUNC_W-1:0] func,
                           input logic signed [VAL_W-1:0] value);
        miq_pkg::t_req req;
        int gap;
        req.func = func;
        req.value = value;
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        expected_rsp[exp_wr_idx % EXP_DEPTH] = apply_queue_op(req);
        exp_wr_idx++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_random_store(input int insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            send_op(miq_pkg::FUNC_INSERT, $urandom);
        else
            send_op(miq_pkg::FUNC_PUSH, $urandom);
    endtask

    always @(posedge i_clk) begin
        miq_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_done) begin
            if (exp_wr_idx == exp_rd_idx) begin
                $error("result with no transaction outstanding: status %0d value %0d occ %0d",
                       o_rsp.status, o_rsp.popped_value, o_rsp.occupancy);
                failed = 1'b1;
            end else begin
                exp_rsp = expected_rsp[exp_rd_idx % EXP_DEPTH];
                exp_rd_idx++;
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_rsp.status, o_rsp.status);
                    failed = 1'b1;
                end
                if (o_rsp.popped_value !== exp_rsp.popped_value) begin
                    $error("popped_value mismatch: expected %0d, actual %0d",
                           exp_rsp.popped_value, o_rsp.popped_value);
                    failed = 1'b1;
                end
                if (o_rsp.occupancy !== exp_rsp.occupancy) begin
                    $error("occupancy mismatch: expected %0d, actual %0d",
                           exp_rsp.occupancy, o_rsp.occupancy);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic test_basic_ops();
        send_op(miq_pkg::FUNC_POP, 32'sh1234_5678);
        send_op(FUNC_NOP, -1);
        send_op(miq_pkg::FUNC_PUSH, 32'sh8000_0000);
        send_op(miq_pkg::FUNC_PUSH, 32'sh7fff_ffff);
        send_op(miq_pkg::FUNC_INSERT, 32'sh0000_0000);
        send_op(miq_pkg::FUNC_PUSH, -1);
        send_op(miq_pkg::FUNC_INSERT, 32'sh5555_5555);
        send_op(miq_pkg::FUNC_INSERT, 32'shaaaa_aaaa);
        send_op(FUNC_NOP, 32'sh0000_0001);
        send_op(miq_pkg::FUNC_PUSH, 32'sh0000_0001);
        send_op(miq_pkg::FUNC_POP, 0);
        send_op(miq_pkg::FUNC_INSERT, 32'shffff_fffe);
        repeat (8) send_op(miq_pkg::FUNC_POP, -1);
        send_op(miq_pkg::FUNC_INSERT, 32'sh0f0f_0f0f);
        send_op(miq_pkg::FUNC_POP, 0);
        send_op(miq_pkg::FUNC_POP, 0);
    endtask

    task automatic test_grow_and_drain();
        while (queue_level() < 96) send_random_store(40);
        send_op(miq_pkg::FUNC_PUSH, $urandom);
        send_op(miq_pkg::FUNC_INSERT, $urandom);
        send_op(miq_pkg::FUNC_POP, 0);
        send_op(miq_pkg::FUNC_INSERT, $urandom);
        send_op(miq_pkg::FUNC_INSERT, $urandom);
        send_op(miq_pkg::FUNC_PUSH, $urandom);
        while (queue_level() > 0) begin
            if ($urandom_range(0, 19) == 0)
                send_random_store(50);
            else
                send_op(miq_pkg::FUNC_POP, $urandom);
        end
        send_op(miq_pkg::FUNC_POP, $urandom);
    endtask

    task automatic test_random_mix(input int num_ops);
        int sent;
        int phase_len;
        int grow_pct;
        int pick;
        sent = 0;
        while (sent < num_ops) begin
            phase_len = $urandom_range(10, 60);
            grow_pct = ($urandom_range(0, 1) == 1) ? 70 : 30;
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_op(FUNC_NOP, $urandom);
                else if (pick < 4 + grow_pct)
                    send_random_store(45);
                else
                    send_op(miq_pkg::FUNC_POP, $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_grow_and_drain();
        test_random_mix(200);
        start <= 1'b0;
        while (exp_wr_idx != exp_rd_idx) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (!failed && exp_wr_idx == exp_rd_idx)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
